>>> rtl/lsbse_pkg.sv
// Package for the LSB pixel embed / extract block.
// Holds sizes, codes and the result record; used by the top level only via scoped names.
`timescale 1ns / 1ps

package lsbse_pkg;

	localparam int MSG_DEPTH = 256;
	localparam int MSG_AW    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
	localparam int CNT_W     = $clog2(MSG_DEPTH + 1);
	localparam int BP_W      = $clog2(MSG_DEPTH + 2);

	localparam int PIX_W = 24;
	localparam logic [24:0] MAX_PIXELS = 25'd16777216;

	localparam logic [7:0] MARK_MASK = 8'b1111_1000;
	localparam logic [7:0] MARK_VAL  = 8'b1010_0000;
	localparam logic [7:0] ZERO_BYTE = 8'b0000_0000;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic IN_PIXEL = 1'b0;
	localparam logic IN_BYTE  = 1'b1;

	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_PIXELS = 1'b1;

	localparam logic [1:0] OK_PIXEL = 2'd0;
	localparam logic [1:0] OK_TEXT  = 2'd1;
	localparam logic [1:0] OK_END   = 2'd2;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MARKED   = 3'd1;
	localparam logic [2:0] ST_TOO_LONG = 3'd2;
	localparam logic [2:0] ST_NO_MARK  = 3'd3;
	localparam logic [2:0] ST_DAMAGED  = 3'd4;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] text;
		logic [2:0] status;
		logic       last;
	} result_t;

endpackage

>>> rtl/lsb_stego_pixel_embed_extract_top.sv
// Top level of the LSB pixel embed / extract block: registers, message memory,
// pixel pipeline and output queue. Depends on lsbse_pkg.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_stall   kind msg_byte red_in green_in blue_in
//  output    out        out_valid / out_stall out_kind red_out green_out blue_out
//                                             text_byte status last
//  config    in/out     APB psel / penable    paddr pwdata prdata pready
//
// One request per cycle while in_stall is low; results pass stage one, then the output queue.
// Stage one updates the counters and reads the message memory (synchronous read);
// stage two sets the carrier bit and queues up to two results.
// Reset clears all control state; the message memory is not cleared.
// in_stall rises only when the eight-entry output queue could overflow.
`timescale 1ns / 1ps

module lsb_stego_pixel_embed_extract_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  msg_byte,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  text_byte,
	output logic [2:0]  status,
	output logic        last
);

	localparam int AW  = lsbse_pkg::MSG_AW;
	localparam int CW  = lsbse_pkg::CNT_W;
	localparam int BW  = lsbse_pkg::BP_W;
	localparam int PW  = lsbse_pkg::PIX_W;
	localparam int QA  = lsbse_pkg::FIFO_AW;
	localparam int QC  = lsbse_pkg::FIFO_CW;

	// configuration
	logic          mode_q;
	logic [24:0]   pixels_q;
	logic [PW-1:0] lim_m1_q;
	logic          cfg_wr;

	// block state
	logic [CW-1:0] count_q, count_d;
	logic          ovf_q, ovf_d;
	logic [PW-1:0] pix_q, pix_d;
	logic [2:0]    phase_q, phase_d;
	logic [2:0]    bitpos_q, bitpos_d;
	logic [BW-1:0] bp_q, bp_d;
	logic [7:0]    shift_q, shift_d;
	logic [2:0]    istat_q, istat_d;
	logic          done_q, done_d;

	logic [7:0] mem [lsbse_pkg::MSG_DEPTH];
	logic       mem_we;

	// stage one
	logic                v_s1;
	lsbse_pkg::result_t  res0_s1, res1_s1;
	logic [1:0]          nres_s1;
	logic                emb_s1, zero_s1;
	logic [2:0]          bsel_s1;
	lsbse_pkg::chan_t    chan_s1;
	logic [7:0]          rd_data_s1;

	lsbse_pkg::result_t  res0, res1, res0_fix;
	logic [1:0]          nres;
	logic                emb, zero_b;
	lsbse_pkg::chan_t    chan;
	logic                acc, fin, bit_v;

	// output queue
	lsbse_pkg::result_t  q_mem [lsbse_pkg::FIFO_DEPTH];
	logic [QA-1:0]       q_wr_q, q_rd_q, q_wr1;
	logic [QC-1:0]       q_cnt_q;
	logic                pop;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		prdata = 32'd0;
		unique case (paddr[2])
			lsbse_pkg::REG_MODE:   prdata = {31'd0, mode_q};
			lsbse_pkg::REG_PIXELS: prdata = {7'd0, pixels_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= lsbse_pkg::MODE_EMBED;
			pixels_q <= 25'd1;
			lim_m1_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				lsbse_pkg::REG_MODE: begin
					mode_q <= pwdata[0];
				end
				lsbse_pkg::REG_PIXELS: begin
					pixels_q <= pwdata[24:0];
					if (pwdata[24:0] == 25'd0)
						lim_m1_q <= '0;
					else if (pwdata[24:0] >= lsbse_pkg::MAX_PIXELS)
						lim_m1_q <= '1;
					else
						lim_m1_q <= PW'(pwdata[24:0] - 25'd1);
				end
			endcase
		end
	end

	// stall when queue plus the request already in flight could fill it
	assign in_stall = (QC'(q_cnt_q) + (v_s1 ? QC'(2) : QC'(0)))
		> QC'(lsbse_pkg::FIFO_DEPTH - 2);
	assign acc = in_valid & ~in_stall;
	assign fin = pix_q >= lim_m1_q;

	always_comb begin
		logic [7:0] r;
		logic [7:0] nshift;
		logic       ebit;
		count_d  = count_q;
		ovf_d    = ovf_q;
		pix_d    = pix_q;
		phase_d  = phase_q;
		bitpos_d = bitpos_q;
		bp_d     = bp_q;
		shift_d  = shift_q;
		istat_d  = istat_q;
		done_d   = done_q;
		mem_we   = 1'b0;
		res0     = '0;
		res1     = '0;
		nres     = 2'd0;
		emb      = 1'b0;
		zero_b   = 1'b1;
		r        = red_in;
		nshift   = shift_q;
		ebit     = 1'b0;
		if (phase_q[0] == 1'b0)
			chan = lsbse_pkg::CH_GREEN;
		else if (phase_q == 3'd3)
			chan = lsbse_pkg::CH_BLUE;
		else
			chan = lsbse_pkg::CH_RED;
		unique case (chan)
			lsbse_pkg::CH_GREEN: ebit = green_in[0];
			lsbse_pkg::CH_BLUE:  ebit = blue_in[0];
			lsbse_pkg::CH_RED:   ebit = red_in[0];
			default:             ebit = red_in[0];
		endcase

		if (kind == lsbse_pkg::IN_BYTE) begin
			if (pix_q == '0) begin
				if (count_q < CW'(lsbse_pkg::MSG_DEPTH)) begin
					mem_we  = 1'b1;
					count_d = count_q + CW'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end
		end else begin
			if (mode_q == lsbse_pkg::MODE_EMBED) begin
				if (pix_q == '0) begin
					bp_d     = '0;
					bitpos_d = '0;
					if ((red_in & lsbse_pkg::MARK_MASK) == lsbse_pkg::MARK_VAL)
						istat_d = lsbse_pkg::ST_MARKED;
					else if (ovf_q || ((32'(count_q) + 32'd1) << 3) > 32'(lim_m1_q))
						istat_d = lsbse_pkg::ST_TOO_LONG;
					else begin
						istat_d = lsbse_pkg::ST_OK;
						r = (red_in & ~lsbse_pkg::MARK_MASK) | lsbse_pkg::MARK_VAL;
					end
				end else if (istat_q == lsbse_pkg::ST_OK && bp_q <= BW'(count_q)) begin
					emb    = 1'b1;
					zero_b = ~(bp_q < BW'(count_q));
					if (bitpos_q == 3'd7) begin
						bitpos_d = '0;
						bp_d     = bp_q + BW'(1);
					end else begin
						bitpos_d = bitpos_q + 3'd1;
					end
				end
				res0 = '{kind: lsbse_pkg::OK_PIXEL, red: r, green: green_in, blue: blue_in,
					text: lsbse_pkg::ZERO_BYTE, status: istat_d, last: fin};
				nres = 2'd1;
			end else begin
				if (pix_q == '0) begin
					done_d   = 1'b0;
					bitpos_d = '0;
					shift_d  = '0;
					if ((red_in & lsbse_pkg::MARK_MASK) == lsbse_pkg::MARK_VAL) begin
						istat_d = lsbse_pkg::ST_OK;
					end else begin
						istat_d = lsbse_pkg::ST_NO_MARK;
						done_d  = 1'b1;
						res0 = '{kind: lsbse_pkg::OK_END, red: 8'd0, green: 8'd0, blue: 8'd0,
							text: 8'd0, status: lsbse_pkg::ST_NO_MARK, last: 1'b1};
						nres = 2'd1;
					end
				end else if (!done_q) begin
					nshift = {shift_q[6:0], ebit};
					if (bitpos_q == 3'd7) begin
						bitpos_d = '0;
						shift_d  = '0;
						if (nshift == lsbse_pkg::ZERO_BYTE) begin
							done_d = 1'b1;
							res0 = '{kind: lsbse_pkg::OK_END, red: 8'd0, green: 8'd0,
								blue: 8'd0, text: 8'd0, status: lsbse_pkg::ST_OK, last: 1'b1};
						end else begin
							res0 = '{kind: lsbse_pkg::OK_TEXT, red: 8'd0, green: 8'd0,
								blue: 8'd0, text: nshift, status: lsbse_pkg::ST_OK, last: 1'b0};
						end
						nres = 2'd1;
					end else begin
						bitpos_d = bitpos_q + 3'd1;
						shift_d  = nshift;
					end
				end
				if (fin && !done_d) begin
					istat_d = lsbse_pkg::ST_DAMAGED;
					done_d  = 1'b1;
					if (nres == 2'd0) begin
						res0 = '{kind: lsbse_pkg::OK_END, red: 8'd0, green: 8'd0, blue: 8'd0,
							text: 8'd0, status: lsbse_pkg::ST_DAMAGED, last: 1'b1};
						nres = 2'd1;
					end else begin
						res1 = '{kind: lsbse_pkg::OK_END, red: 8'd0, green: 8'd0, blue: 8'd0,
							text: 8'd0, status: lsbse_pkg::ST_DAMAGED, last: 1'b1};
						nres = 2'd2;
					end
				end
			end
			if (fin) begin
				pix_d   = '0;
				phase_d = '0;
				if (mode_q == lsbse_pkg::MODE_EMBED) begin
					count_d = '0;
					ovf_d   = 1'b0;
				end
			end else begin
				pix_d   = pix_q + PW'(1);
				phase_d = (phase_q >= 3'd5) ? 3'd0 : phase_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			pix_q    <= '0;
			phase_q  <= '0;
			bitpos_q <= '0;
			bp_q     <= '0;
			shift_q  <= '0;
			istat_q  <= lsbse_pkg::ST_OK;
			done_q   <= 1'b0;
			v_s1     <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (acc) begin
				count_q  <= count_d;
				ovf_q    <= ovf_d;
				pix_q    <= pix_d;
				phase_q  <= phase_d;
				bitpos_q <= bitpos_d;
				bp_q     <= bp_d;
				shift_q  <= shift_d;
				istat_q  <= istat_d;
				done_q   <= done_d;
			end
		end
	end

	// message memory, synchronous read
	always_ff @(posedge clk) begin
		if (acc && mem_we)
			mem[count_q[AW-1:0]] <= msg_byte;
		if (acc)
			rd_data_s1 <= mem[bp_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res0_s1 <= res0;
			res1_s1 <= res1;
			nres_s1 <= nres;
			emb_s1  <= emb;
			zero_s1 <= zero_b;
			bsel_s1 <= 3'd7 - bitpos_q;
			chan_s1 <= chan;
		end
	end

	// stage two: place the message bit
	assign bit_v = zero_s1 ? 1'b0 : rd_data_s1[bsel_s1];

	always_comb begin
		res0_fix = res0_s1;
		if (emb_s1) begin
			unique case (chan_s1)
				lsbse_pkg::CH_GREEN: res0_fix.green[0] = bit_v;
				lsbse_pkg::CH_BLUE:  res0_fix.blue[0]  = bit_v;
				lsbse_pkg::CH_RED:   res0_fix.red[0]   = bit_v;
				default:             res0_fix.red[0]   = bit_v;
			endcase
		end
	end

	assign q_wr1 = q_wr_q + QA'(1);
	assign pop   = out_valid & ~out_stall;

	always_ff @(posedge clk) begin
		if (v_s1 && nres_s1 != 2'd0)
			q_mem[q_wr_q] <= res0_fix;
		if (v_s1 && nres_s1 == 2'd2)
			q_mem[q_wr1] <= res1_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q  <= '0;
			q_rd_q  <= '0;
			q_cnt_q <= '0;
		end else begin
			if (v_s1)
				q_wr_q <= q_wr_q + QA'(nres_s1);
			if (pop)
				q_rd_q <= q_rd_q + QA'(1);
			q_cnt_q <= q_cnt_q + (v_s1 ? QC'(nres_s1) : QC'(0)) - (pop ? QC'(1) : QC'(0));
		end
	end

	assign out_valid = q_cnt_q != '0;
	assign out_kind  = q_mem[q_rd_q].kind;
	assign red_out   = q_mem[q_rd_q].red;
	assign green_out = q_mem[q_rd_q].green;
	assign blue_out  = q_mem[q_rd_q].blue;
	assign text_byte = q_mem[q_rd_q].text;
	assign status    = q_mem[q_rd_q].status;
	assign last      = q_mem[q_rd_q].last;

endmodule
